@@ design/miller_rabin_primality_assert.svh @@
// assertion macros shared by the checker
`ifndef MILLER_RABIN_PRIMALITY_ASSERT_SVH
`define MILLER_RABIN_PRIMALITY_ASSERT_SVH
// implication checked every edge out of reset
`define MRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ design/mrp_pkg.sv @@
// ----------------------------------------------------------------------------
// mrp_pkg
// shared types and constants for the primality tester
// ----------------------------------------------------------------------------
package mrp_pkg;
    localparam int unsigned FieldW = 32;
    typedef logic [FieldW-1:0] t_field;
    // control from sequencer to modular multiplier
    typedef struct packed {
        logic start;
    } t_mul_ctl;
    typedef struct packed {
        logic done;
    } t_mul_sts;
endpackage

@@ design/mrp_if.sv @@
// ----------------------------------------------------------------------------
// mrp_in_if / mrp_out_if
// valid/ready channels carrying one beat of input or result
// ----------------------------------------------------------------------------
interface mrp_in_if import mrp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field number;
    t_field witness;
    logic   last_witness;
    modport source (output valid, number, witness, last_witness, input ready);
    modport sink (input valid, number, witness, last_witness, output ready);
endinterface

interface mrp_out_if;
    logic valid;
    logic ready;
    logic probable_prime;
    logic trivial_case;
    modport source (output valid, probable_prime, trivial_case, input ready);
    modport sink (input valid, probable_prime, trivial_case, output ready);
endinterface

@@ design/mrp_modmul.sv @@
// ----------------------------------------------------------------------------
// mrp_modmul
// bit-serial interleaved modular multiplier, msb of b first
// ----------------------------------------------------------------------------
module mrp_modmul import mrp_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mul_ctl         i_ctl,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_n,
    output t_mul_sts         o_sts,
    output logic [WIDTH-1:0] o_p
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_b;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;
    logic [WIDTH+1:0] w_dbl, w_d1, w_add, w_a1;

    // acc < n throughout, so each step needs at most one subtract after
    // doubling and one after adding
    always_comb begin
        w_dbl = {1'b0, r_acc, 1'b0};
        w_d1  = (w_dbl >= {2'b00, i_n}) ? w_dbl - {2'b00, i_n} : w_dbl;
        w_add = w_d1 + (r_b[WIDTH-1] ? {2'b00, i_a} : '0);
        w_a1  = (w_add >= {2'b00, i_n}) ? w_add - {2'b00, i_n} : w_add;
        n_acc = w_a1[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc <= '0;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[WIDTH-2:0], 1'b0};
        end
    end

    assign o_sts.done = r_done;
    assign o_p        = r_acc;
endmodule

@@ design/miller_rabin_primality.sv @@
// ----------------------------------------------------------------------------
// miller_rabin_primality
// one Miller-Rabin witness round per input beat, verdict on the last witness
// ----------------------------------------------------------------------------
// Each input beat runs one round on number n with the given witness. Only the
// low WIDTH bits of both fields are used. All products go through a single
// bit-serial modular multiplier. A round is one reduction of the witness
// plus the stripping of the factors of two from n-1, then WIDTH squarings
// with a multiply for each set bit of d, then up to s-1 further squarings,
// which stop early when x reaches 1 or n-1. Small numbers (n<=4) and even n
// skip the multiplier. Only one beat is worked on at a time. A result is
// given only for beats with last_witness set, and while it waits in the
// output register the next beat is held off.
module miller_rabin_primality import mrp_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrp_in_if.sink    i_in,
    mrp_out_if.source o_out
);
    localparam int CW = $clog2(WIDTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SPLIT = 4'd1;
    localparam logic [3:0] S_RED   = 4'd2;
    localparam logic [3:0] S_PSQ   = 4'd3;
    localparam logic [3:0] S_PMUL  = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_SQ    = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_WAITM = 4'd8;
    localparam logic [3:0] S_LOOP  = 4'd15;

    logic [3:0]       r_state, r_ret;
    logic [WIDTH-1:0] r_n, r_x, r_a, r_d;
    logic [CW-1:0]    r_s, r_bits;
    logic             r_last, r_comp_round, r_seen;
    logic             r_ovalid, r_prime, r_triv;
    logic [WIDTH-1:0] r_ma, r_mb, w_p, w_nm1;
    t_mul_ctl         r_ctl;
    t_mul_sts         w_sts;
    logic             w_take;

    mrp_modmul #(.WIDTH(WIDTH)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (r_ctl),
        .i_a    (r_ma),
        .i_b    (r_mb),
        .i_n    (r_n),
        .o_sts  (w_sts),
        .o_p    (w_p)
    );

    assign w_nm1       = r_n - 1'b1;
    assign i_in.ready  = (r_state == S_IDLE) && !(r_ovalid && !o_out.ready);
    assign w_take      = i_in.valid && i_in.ready;
    assign o_out.valid = r_ovalid;
    assign o_out.probable_prime = r_prime;
    assign o_out.trivial_case   = r_triv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seen   <= 1'b0;
            r_ovalid <= 1'b0;
            r_ctl    <= '0;
        end else begin
            r_ctl <= '0;
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_n    <= i_in.number[WIDTH-1:0];
                        r_a    <= i_in.witness[WIDTH-1:0];
                        r_last <= i_in.last_witness;
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    r_d <= w_nm1;
                    r_s <= '0;
                    if (r_n <= WIDTH'(4)) begin
                        // small-number rule, flag cleared on a last beat, else untouched
                        if (r_last) begin
                            r_ovalid <= 1'b1;
                            r_triv   <= 1'b1;
                            r_prime  <= (r_n == WIDTH'(2)) || (r_n == WIDTH'(3));
                            r_seen   <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end else if (!r_n[0]) begin
                        r_comp_round <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        // reduce witness: 1*a mod n, a shifted in serially
                        r_ma   <= WIDTH'(1);
                        r_mb   <= r_a;
                        r_ctl.start <= 1'b1;
                        r_ret  <= S_RED;
                        r_state <= S_WAITM;
                    end
                end
                S_WAITM: begin
                    if (w_sts.done) begin
                        r_state <= r_ret;
                    end
                end
                S_RED: begin
                    r_a <= w_p;
                    // strip factors of two from d, one per cycle
                    if (!r_d[0]) begin
                        r_d <= r_d >> 1;
                        r_s <= r_s + 1'b1;
                    end else begin
                        r_x    <= WIDTH'(1);
                        r_bits <= CW'(WIDTH);
                        r_state <= S_PSQ;
                    end
                end
                S_PSQ: begin
                    // left-to-right: x = x^2, then x*a if bit set
                    if (r_bits == '0) begin
                        r_state <= S_CHK;
                    end else begin
                        r_ma <= r_x;
                        r_mb <= r_x;
                        r_ctl.start <= 1'b1;
                        r_ret <= S_PMUL;
                        r_state <= S_WAITM;
                    end
                end
                S_PMUL: begin
                    r_bits <= r_bits - 1'b1;
                    r_d    <= {r_d[WIDTH-2:0], 1'b0};
                    if (r_d[WIDTH-1]) begin
                        r_ma <= w_p;
                        r_mb <= r_a;
                        r_ctl.start <= 1'b1;
                        r_ret <= S_SQ;
                        r_state <= S_WAITM;
                    end else begin
                        r_x <= w_p;
                        r_state <= S_PSQ;
                    end
                end
                S_SQ: begin
                    // returns here after a multiply inside exponentiation
                    r_x <= w_p;
                    r_state <= S_PSQ;
                end
                S_CHK: begin
                    if (r_x == WIDTH'(1) || r_x == w_nm1) begin
                        r_comp_round <= 1'b0;
                        r_state <= S_FIN;
                    end else if (r_s <= CW'(1)) begin
                        r_comp_round <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_s  <= r_s - 1'b1;
                        r_ma <= r_x;
                        r_mb <= r_x;
                        r_ctl.start <= 1'b1;
                        r_ret <= S_LOOP;
                        r_state <= S_WAITM;
                    end
                end
                S_FIN: begin
                    if (r_last) begin
                        r_ovalid <= 1'b1;
                        r_triv   <= 1'b0;
                        r_prime  <= !(r_seen || r_comp_round);
                        r_seen   <= 1'b0;
                    end else begin
                        r_seen <= r_seen || r_comp_round;
                    end
                    r_state <= S_IDLE;
                end
                S_LOOP: begin
                    // squaring loop step
                    r_x <= w_p;
                    if (w_p == WIDTH'(1)) begin
                        r_comp_round <= 1'b1;
                        r_state <= S_FIN;
                    end else if (w_p == w_nm1) begin
                        r_comp_round <= 1'b0;
                        r_state <= S_FIN;
                    end else if (r_s <= CW'(1)) begin
                        r_comp_round <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_s  <= r_s - 1'b1;
                        r_ma <= w_p;
                        r_mb <= w_p;
                        r_ctl.start <= 1'b1;
                        r_ret <= S_LOOP;
                        r_state <= S_WAITM;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ design/mrp_checker.sv @@
// ----------------------------------------------------------------------------
// mrp_checker
// port-level checks on the primality tester, bound to the top level
// ----------------------------------------------------------------------------
`include "miller_rabin_primality_assert.svh"
module mrp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic i_ready,
    input logic i_last,
    input logic o_valid,
    input logic o_ready,
    input logic o_prime,
    input logic o_triv
);
    `MRP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !o_ready, o_valid && $stable(o_prime) && $stable(o_triv), "result beat changed while stalled")
    `MRP_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && i_ready, !i_ready, "second beat taken while busy")
    `MRP_ASSERT_NEXT(a_nolast, i_clk, i_rst_n, i_valid && i_ready && !i_last, !$rose(o_valid), "result for non-final witness")
endmodule

bind miller_rabin_primality mrp_checker u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_in.valid),
    .i_ready(i_in.ready),
    .i_last (i_in.last_witness),
    .o_valid(o_out.valid),
    .o_ready(o_out.ready),
    .o_prime(o_out.probable_prime),
    .o_triv (o_out.trivial_case)
);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// randomised and directed test of the Miller-Rabin primality tester
// ----------------------------------------------------------------------------
// Drives witness rounds through the input channel, predicts each verdict with
// a behavioural Miller-Rabin round and compares every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;
    import mrp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH = 32;
    localparam longint unsigned CycleLimit = 3_000_000;

    typedef struct packed {
        logic probable_prime;
        logic trivial_case;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    mrp_in_if  in_ch ();
    mrp_out_if out_ch ();

    miller_rabin_primality #(.WIDTH(WIDTH)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_verdict verdict_q[$];
    bit composite_flag;
    int errors = 0;
    longint unsigned cycles = 0;
    bit no_idle;

    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
        return (a * b) % n;
    endfunction

    // true when this round proves n composite, n >= 5
    function automatic bit round_fails(logic [63:0] n, logic [63:0] a);
        logic [63:0] d, x, base, e;
        int s;
        if (!n[0]) return 1'b1;
        d = n - 1;
        s = 0;
        while (!d[0] && d != 0) begin
            d >>= 1;
            s++;
        end
        x = 1;
        base = a % n;
        e = d;
        while (e != 0) begin
            if (e[0]) x = mulmod(x, base, n);
            e >>= 1;
            base = mulmod(base, base, n);
        end
        if (x == 1 || x == n - 1) return 1'b0;
        for (int i = 1; i < s; i++) begin
            x = mulmod(x, x, n);
            if (x == 1) return 1'b1;
            if (x == n - 1) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_round(logic [31:0] num, logic [31:0] wit, logic last);
        logic [63:0] n;
        t_verdict v;
        bit triv;
        n = {32'b0, num};
        triv = 1'b0;
        v = '0;
        if (n <= 1 || n == 4) begin
            triv = 1'b1;
            v.probable_prime = 1'b0;
        end else if (n <= 3) begin
            triv = 1'b1;
            v.probable_prime = 1'b1;
        end else if (round_fails(n, {32'b0, wit})) begin
            composite_flag = 1'b1;
        end
        if (last) begin
            if (!triv) v.probable_prime = !composite_flag;
            v.trivial_case = triv;
            verdict_q.push_back(v);
            composite_flag = 1'b0;
        end
    endtask

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // leaves valid high after the accepting edge; the next call or drain()
    // replaces or drops the beat in that same time step
    task automatic send_round(logic [31:0] num, logic [31:0] wit, logic last);
        while (!no_idle && $urandom_range(99) < 21) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.number <= num;
        in_ch.witness <= wit;
        in_ch.last_witness <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_round(num, wit, last);
    endtask

    // receiver stalls and result checking
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    t_verdict exp_v;
                    exp_v = verdict_q.pop_front();
                    if (out_ch.probable_prime !== exp_v.probable_prime)
                        report($sformatf("probable_prime %b expected %b",
                            out_ch.probable_prime, exp_v.probable_prime));
                    if (out_ch.trivial_case !== exp_v.trivial_case)
                        report($sformatf("trivial_case %b expected %b",
                            out_ch.trivial_case, exp_v.trivial_case));
                end
            end
        end
        out_ch.ready <= i_rst_n && (no_idle || ($urandom_range(99) >= 21));
    end

    function automatic logic [31:0] odd_number(bit wide);
        logic [31:0] n;
        n = wide ? $urandom() : $urandom_range(5000, 5);
        n[0] = 1'b1;
        if (n < 5) n = 5;
        return n;
    endfunction

    function automatic logic [31:0] pick_witness(logic [31:0] n);
        if (n < 5) return $urandom();
        return 32'd2 + ($urandom() % (n - 32'd3));
    endfunction

    task automatic test_trivial();
        send_round(0, 0, 1'b1);
        send_round(1, 32'hffff_ffff, 1'b1);
        send_round(2, 7, 1'b1);
        send_round(3, 2, 1'b1);
        send_round(4, 2, 1'b0);
        send_round(4, 3, 1'b1);
    endtask

    task automatic test_directed();
        send_round(5, 2, 1'b1);
        send_round(97, 2, 1'b0);
        send_round(97, 5, 1'b1);
        send_round(561, 2, 1'b1);              // carmichael number
        send_round(2047, 2, 1'b1);             // strong pseudoprime to base 2
        send_round(2047, 3, 1'b1);
        send_round(6, 2, 1'b1);                // even composite
        send_round(32'hffff_fffe, 3, 1'b1);
        send_round(32'hffff_fffb, 2, 1'b0);    // largest 32-bit prime
        send_round(32'hffff_fffb, 32'hffff_fff9, 1'b1);
        send_round(32'hffff_ffff, 32'hffff_fffd, 1'b1);
        send_round(13, 26, 1'b1);              // witness zero mod n
        send_round(13, 32'hffff_ffff, 1'b1);
        send_round(9, 2, 1'b0);                // composite seen then trivial
        send_round(2, 0, 1'b1);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic test_random(int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            logic [31:0] n;
            int rounds;
            bit wide;
            wide = ($urandom_range(9) == 0);
            case ($urandom_range(9))
                0: n = $urandom_range(6);
                1: n = $urandom();
                default: n = odd_number(wide);
            endcase
            rounds = $urandom_range(3, 1);
            for (int r = 0; r < rounds; r++) begin
                send_round(n, ($urandom_range(19) == 0) ? $urandom() : pick_witness(n),
                    r == rounds - 1);
                sent++;
            end
            if (sent > count / 2 && sent < count / 2 + 4) drain();
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.number = '0;
        in_ch.witness = '0;
        in_ch.last_witness = 1'b0;
        composite_flag = 1'b0;
        no_idle = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_trivial();
        test_directed();
        no_idle = 1'b1;
        test_random(40);
        no_idle = 1'b0;
        test_random(120);
        drain();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+design
design/mrp_pkg.sv
design/mrp_if.sv
design/mrp_modmul.sv
design/miller_rabin_primality.sv
design/mrp_checker.sv
dv/tb_top.sv
